/* design/bal_pkg.sv */
`timescale 1ns / 1ps

package bal_pkg;

  // Storage depth of the list and derived widths
  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = 6;   // entry_count / capacity field width
  localparam int VW    = 32;  // value width
  localparam int PW    = 5;   // position field width

  typedef enum logic [2:0] {
    OP_APPEND       = 3'd0,
    OP_REMOVE_LAST  = 3'd1,
    OP_REMOVE_FIRST = 3'd2,
    OP_REMOVE_AT    = 3'd3,
    OP_SEARCH       = 3'd4,
    OP_NOP5         = 3'd5,
    OP_NOP6         = 3'd6,
    OP_NOP7         = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_SCAN,
    S_SCAN_END,
    S_EMIT
  } state_t;

  // RAM read address select
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_START_NEXT,
    RD_IDX_NEXT,
    RD_IDX_SKIP
  } rd_sel_t;

  // What the output register loads
  typedef enum logic [1:0] {
    OUT_PLAIN,
    OUT_PEND_MID,
    OUT_PEND_LAST
  } out_kind_t;

  typedef struct packed {
    logic      latch;
    logic      wr_append;
    logic      wr_shift;
    logic      cnt_dec;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      idx_load_start;
    logic      idx_inc;
    logic      pend_set;
    logic      pend_clear;
    logic      out_load;
    out_kind_t out_kind;
    status_t   out_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic range_bad;
    logic start_more;
    logic idx_more;
    logic idx_more2;
    logic match;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

/* design/bal_ram.sv */
`timescale 1ns / 1ps

module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/bal_ctrl.sv */
`timescale 1ns / 1ps

module bal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  bal_pkg::stat_t stat,
  output bal_pkg::cmd_t  cmd
);

  bal_pkg::state_t  state, state_next;
  bal_pkg::status_t st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bal_pkg::S_IDLE;
      st    <= bal_pkg::ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

  always_comb begin
    state_next     = state;
    st_next        = st;
    s_tready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = bal_pkg::RD_ZERO;
    cmd.out_kind   = bal_pkg::OUT_PLAIN;
    cmd.out_status = st;

    case (state)
      bal_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = bal_pkg::S_EXEC;
        end
      end

      bal_pkg::S_EXEC: begin
        st_next    = bal_pkg::ST_OK;
        state_next = bal_pkg::S_EMIT;
        case (stat.op)
          bal_pkg::OP_APPEND: begin
            if (stat.full) st_next = bal_pkg::ST_FULL;
            else cmd.wr_append = 1'b1;
          end
          bal_pkg::OP_REMOVE_LAST: begin
            if (stat.empty) st_next = bal_pkg::ST_EMPTY;
            else cmd.cnt_dec = 1'b1;
          end
          bal_pkg::OP_REMOVE_FIRST, bal_pkg::OP_REMOVE_AT: begin
            if (stat.empty) begin
              st_next = bal_pkg::ST_EMPTY;
            end else if (stat.op == bal_pkg::OP_REMOVE_AT && stat.range_bad) begin
              st_next = bal_pkg::ST_RANGE;
            end else begin
              cmd.idx_load_start = 1'b1;
              if (stat.start_more) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bal_pkg::RD_START_NEXT;
                state_next = bal_pkg::S_SHIFT;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
            end
          end
          bal_pkg::OP_SEARCH: begin
            cmd.pend_clear = 1'b1;
            if (!stat.empty) begin
              cmd.idx_load_start = 1'b1;
              cmd.rd_en          = 1'b1;
              cmd.rd_sel         = bal_pkg::RD_ZERO;
              state_next         = bal_pkg::S_SCAN;
            end
          end
          default: ;
        endcase
      end

      // one entry moved down per cycle; next read overlaps this write
      bal_pkg::S_SHIFT: begin
        cmd.wr_shift = 1'b1;
        if (stat.idx_more2) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = bal_pkg::RD_IDX_SKIP;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = bal_pkg::S_EMIT;
        end
      end

      // a match is held back one step so the final one can carry last
      bal_pkg::S_SCAN: begin
        if (!(stat.match && stat.pend_valid && !stat.out_free)) begin
          if (stat.match) begin
            cmd.pend_set = 1'b1;
            if (stat.pend_valid) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = bal_pkg::OUT_PEND_MID;
            end
          end
          if (stat.idx_more) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = bal_pkg::RD_IDX_NEXT;
            cmd.idx_inc = 1'b1;
          end else begin
            state_next = bal_pkg::S_SCAN_END;
          end
        end
      end

      bal_pkg::S_SCAN_END: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = stat.pend_valid ? bal_pkg::OUT_PEND_LAST : bal_pkg::OUT_PLAIN;
          cmd.out_status = bal_pkg::ST_OK;
          state_next     = bal_pkg::S_IDLE;
        end
      end

      bal_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bal_pkg::S_IDLE;
        end
      end

      default: state_next = bal_pkg::S_IDLE;
    endcase
  end

endmodule

/* design/bal_dp.sv */
`timescale 1ns / 1ps

module bal_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [bal_pkg::CW-1:0]   cfg_wdata,
  input  logic [2:0]               in_op,
  input  logic [bal_pkg::VW-1:0]   in_value,
  input  logic [bal_pkg::PW-1:0]   in_position,
  input  bal_pkg::cmd_t            cmd,
  output bal_pkg::stat_t           stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic                     out_hit,
  output logic [bal_pkg::PW-1:0]   out_found_position,
  output logic [bal_pkg::CW-1:0]   out_entry_count,
  output logic                     out_last
);

  localparam int AW = bal_pkg::AW;
  localparam int CW = bal_pkg::CW;

  logic [CW-1:0]          capacity;
  logic [CW-1:0]          count;
  logic [CW-1:0]          cap_eff;
  bal_pkg::op_t           op;
  logic [bal_pkg::VW-1:0] value;
  logic [bal_pkg::PW-1:0] position;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          start;
  logic [AW-1:0]          pend_pos;
  logic                   pend_valid;
  logic [CW-1:0]          start_p1, idx_p1, idx_p2;
  logic [AW-1:0]          raddr, waddr;
  logic [bal_pkg::VW-1:0] wdata, rdata;
  logic                   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(32);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign cap_eff = (capacity > CW'(bal_pkg::DEPTH)) ? CW'(bal_pkg::DEPTH) : capacity;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op       <= bal_pkg::op_t'(in_op);
      value    <= in_value;
      position <= in_position;
    end
  end

  assign start    = (op == bal_pkg::OP_REMOVE_AT) ? AW'(position) : '0;
  assign start_p1 = CW'(start) + CW'(1);
  assign idx_p1   = CW'(idx) + CW'(1);
  assign idx_p2   = CW'(idx) + CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_append) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_load_start) begin
      idx <= start;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.pend_clear) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_set) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_pos <= idx;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      bal_pkg::RD_ZERO:       raddr = '0;
      bal_pkg::RD_START_NEXT: raddr = start_p1[AW-1:0];
      bal_pkg::RD_IDX_NEXT:   raddr = idx_p1[AW-1:0];
      bal_pkg::RD_IDX_SKIP:   raddr = idx_p2[AW-1:0];
      default:                raddr = '0;
    endcase
  end

  assign waddr = cmd.wr_append ? count[AW-1:0] : idx;
  assign wdata = cmd.wr_append ? value : rdata;

  bal_ram #(
    .WIDTH (bal_pkg::VW),
    .DEPTH (bal_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_append | cmd.wr_shift),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry_count <= count;
      case (cmd.out_kind)
        bal_pkg::OUT_PEND_MID: begin
          out_status         <= bal_pkg::ST_OK;
          out_hit            <= 1'b1;
          out_found_position <= bal_pkg::PW'(pend_pos);
          out_last           <= 1'b0;
        end
        bal_pkg::OUT_PEND_LAST: begin
          out_status         <= bal_pkg::ST_OK;
          out_hit            <= 1'b1;
          out_found_position <= bal_pkg::PW'(pend_pos);
          out_last           <= 1'b1;
        end
        default: begin
          out_status         <= cmd.out_status;
          out_hit            <= 1'b0;
          out_found_position <= '0;
          out_last           <= 1'b1;
        end
      endcase
    end
  end

  assign stat.op         = op;
  assign stat.empty      = (count == '0);
  assign stat.full       = (count >= cap_eff);
  assign stat.range_bad  = (CW'(position) >= count);
  assign stat.start_more = (start_p1 < count);
  assign stat.idx_more   = (idx_p1 < count);
  assign stat.idx_more2  = (idx_p2 < count);
  assign stat.match      = (rdata == value);
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

endmodule

/* design/bounded_array_list_engine_core.sv */
`timescale 1ns / 1ps

// Bounded list of signed 32-bit values held in a 32-entry RAM, up to the
// configured capacity (capped at the RAM depth). One request is taken at a
// time. Append, remove-last, unknown operations and flagged requests put
// their result on the master side from the emit state, which follows the
// execute state, and a new request is accepted once that result is loaded.
// Remove-first and remove-at-position move the later entries down one per
// cycle through the RAM port, with position taken as 0 for remove-first.
// Search walks the stored entries one per cycle and emits one result per
// match in ascending order (tlast on the final one) or one miss result; a
// stalled master side holds the walk. The result register lets a new
// request be accepted while the previous result still waits. Entries are
// never cleared; only entries below the count are ever read.
module bounded_array_list_engine_core (
  input  logic        clk,
  input  logic        rst,

  // capacity register
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,

  // request side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [36:32] position, [39:37] zero
  input  logic [2:0]  s_tuser,   // [2:0] operation

  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] status, [2] hit, [7:3] found_position,
                                 // [13:8] entry_count, [15:14] zero
  output logic        m_tlast
);

  bal_pkg::cmd_t  cmd;
  bal_pkg::stat_t stat;

  logic [1:0]              out_status;
  logic                    out_hit;
  logic [bal_pkg::PW-1:0]  out_found_position;
  logic [bal_pkg::CW-1:0]  out_entry_count;

  // sequencing of each request
  bal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, count, compare and result register
  bal_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_op              (s_tuser),
    .in_value           (s_tdata[31:0]),
    .in_position        (s_tdata[36:32]),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_status         (out_status),
    .out_hit            (out_hit),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_last           (m_tlast)
  );

  assign m_tdata = {2'b00, out_entry_count, out_found_position, out_hit, out_status};

endmodule
